>>> hdl/odwc_pkg.sv
`default_nettype none
package odwc_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int ANG_QUARTER     = 1 << (SINE_TABLE_BITS - 2);
  localparam int ANG_SHIFT       = 16 - SINE_TABLE_BITS;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_A_W    = 36;
  localparam int MUL_B_W    = 25;
  localparam int ACC_W      = 64;
  localparam int RND_W      = ACC_W - 16;
  localparam int VEL_W      = 36;
  localparam int TRIG_W     = 18;
  localparam int QUAD_W     = 17;

  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_UPDATE  = 1'b1;

  typedef enum logic [1:0] {
    MODE_WHEELS = 2'd0,
    MODE_GLOBAL = 2'd1,
    MODE_ROBOT  = 2'd2,
    MODE_UNSET  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROBOT_ID = 3'd0,
    CFG_TIMEOUT  = 3'd1,
    CFG_BODY_R   = 3'd2,
    CFG_INV_R    = 3'd3,
    CFG_ANG0     = 3'd4,
    CFG_ANG1     = 3'd5,
    CFG_ANG2     = 3'd6,
    CFG_ANG3     = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_G0, OP_G1, OP_G2, OP_G3, OP_G4,
    OP_W0, OP_W1, OP_W2, OP_W3, OP_W4, OP_W5
  } dp_op_t;

  typedef struct packed {
    logic       take;
    logic       out_load;
    dp_op_t     op;
    logic [1:0] wheel;
  } dp_cmd_t;

  typedef struct packed {
    logic  upd;
    logic  timed_out;
    logic  active;
    mode_t mode;
    logic  absolute;
    logic  out_busy;
  } dp_sts_t;

  typedef logic [SINE_TABLE_BITS-1:0] ang_t;
  typedef logic [SINE_TABLE_BITS-2:0] quad_idx_t;
  typedef logic [QUAD_W-1:0] quad_tab_t [0:ANG_QUARTER];

  // shift-and-subtract quotient, only used while building the table
  function automatic logic [63:0] quot_of(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // first quadrant sine, Q30 Taylor series folded to Q16
  function automatic quad_tab_t build_quad_tab();
    quad_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] d;
    for (int k = 0; k <= ANG_QUARTER; k++) begin
      x    = (64'(k) * PI_HALF_Q30) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      for (int n = 5; n >= 1; n--) begin
        d    = 64'((2 * n) * (2 * n + 1));
        term = ONE_Q30 - quot_of((term * x2) >> 30, d);
      end
      tab[k] = QUAD_W'((((term * x) >> 30) + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam quad_tab_t QUAD_TAB = build_quad_tab();

  function automatic logic signed [TRIG_W-1:0] sin_lookup(ang_t i);
    logic [1:0]                q;
    quad_idx_t                 r;
    quad_idx_t                 k;
    logic signed [TRIG_W-1:0]  v;
    q = i[SINE_TABLE_BITS-1 -: 2];
    r = {1'b0, i[SINE_TABLE_BITS-3:0]};
    k = q[0] ? quad_idx_t'(ANG_QUARTER) - r : r;
    v = $signed({1'b0, QUAD_TAB[k]});
    return q[1] ? -v : v;
  endfunction

  function automatic logic signed [TRIG_W-1:0] cos_lookup(ang_t i);
    return sin_lookup(i + ang_t'(ANG_QUARTER));
  endfunction

  function automatic ang_t angle_index(logic [15:0] a);
    logic [16:0] s;
    s = {1'b0, a} + 17'(1 << (ANG_SHIFT - 1));
    return s[ANG_SHIFT +: SINE_TABLE_BITS];
  endfunction

  // floor(v / 2^16 + 1/2)
  function automatic logic signed [RND_W-1:0] round16(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] sh;
    t  = v + ACC_W'(32768);
    sh = t >>> 16;
    return sh[RND_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/odwc_if.sv
`default_nettype none
interface odwc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  target_id;
  logic [1:0]  mode;
  logic        absolute_angle;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic signed [31:0] value_d;
  logic [15:0] heading;
  logic [31:0] now_ms;

  modport source (output valid, req_type, target_id, mode, absolute_angle,
                  value_a, value_b, value_c, value_d, heading, now_ms,
                  input ready);
  modport sink (input valid, req_type, target_id, mode, absolute_angle,
                value_a, value_b, value_c, value_d, heading, now_ms,
                output ready);
endinterface

interface odwc_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] wheel0_target;
  logic signed [31:0] wheel1_target;
  logic signed [31:0] wheel2_target;
  logic signed [31:0] wheel3_target;
  logic        timeout_stop;

  modport source (output valid, wheel0_target, wheel1_target, wheel2_target,
                  wheel3_target, timeout_stop, input ready);
  modport sink (input valid, wheel0_target, wheel1_target, wheel2_target,
                wheel3_target, timeout_stop, output ready);
endinterface
`default_nettype wire

>>> hdl/odwc_ctrl.sv
`default_nettype none
module odwc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  odwc_pkg::dp_sts_t sts,
  output odwc_pkg::dp_cmd_t cmd
);
  import odwc_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_G0   = 13'b0000000000010,
    ST_G1   = 13'b0000000000100,
    ST_G2   = 13'b0000000001000,
    ST_G3   = 13'b0000000010000,
    ST_G4   = 13'b0000000100000,
    ST_W0   = 13'b0000001000000,
    ST_W1   = 13'b0000010000000,
    ST_W2   = 13'b0000100000000,
    ST_W3   = 13'b0001000000000,
    ST_W4   = 13'b0010000000000,
    ST_W5   = 13'b0100000000000,
    ST_DONE = 13'b1000000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] wheel, wheel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wheel <= '0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
    end
  end

  always_comb begin
    state_next   = state;
    wheel_next   = wheel;
    cmd.take     = 1'b0;
    cmd.out_load = 1'b0;
    cmd.op       = OP_NONE;
    cmd.wheel    = wheel;
    case (state)
      ST_IDLE: begin
        cmd.take   = 1'b1;
        wheel_next = '0;
        if (sts.upd) begin
          if (sts.timed_out) begin
            if (sts.active) begin
              state_next = ST_DONE;
            end
          end else begin
            case (sts.mode)
              MODE_WHEELS: state_next = ST_DONE;
              MODE_GLOBAL: state_next = sts.absolute ? ST_IDLE : ST_G0;
              MODE_ROBOT:  state_next = ST_W0;
              default:     state_next = ST_IDLE;
            endcase
          end
        end
      end
      ST_G0: begin cmd.op = OP_G0; state_next = ST_G1; end
      ST_G1: begin cmd.op = OP_G1; state_next = ST_G2; end
      ST_G2: begin cmd.op = OP_G2; state_next = ST_G3; end
      ST_G3: begin cmd.op = OP_G3; state_next = ST_G4; end
      ST_G4: begin cmd.op = OP_G4; state_next = ST_W0; end
      ST_W0: begin cmd.op = OP_W0; state_next = ST_W1; end
      ST_W1: begin cmd.op = OP_W1; state_next = ST_W2; end
      ST_W2: begin cmd.op = OP_W2; state_next = ST_W3; end
      ST_W3: begin cmd.op = OP_W3; state_next = ST_W4; end
      ST_W4: begin cmd.op = OP_W4; state_next = ST_W5; end
      ST_W5: begin
        cmd.op = OP_W5;
        if (wheel == 2'd3) begin
          state_next = ST_DONE;
        end else begin
          wheel_next = wheel + 2'd1;
          state_next = ST_W0;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/odwc_datapath.sv
`default_nettype none
module odwc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [odwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [odwc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  odwc_req_if.sink                          req,
  odwc_rsp_if.source                        rsp,
  input  odwc_pkg::dp_cmd_t                 cmd,
  output odwc_pkg::dp_sts_t                 sts
);
  import odwc_pkg::*;

  typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB} mac_t;

  localparam logic signed [RND_W-1:0] S32_MAX = RND_W'(64'sd2147483647);
  localparam logic signed [RND_W-1:0] S32_MIN = RND_W'(-64'sd2147483648);

  // configuration
  logic [7:0]  robot_id;
  logic [15:0] timeout_ms;
  logic [15:0] body_radius;
  logic [23:0] inv_r;
  logic [15:0] wang [4];

  // command state
  logic [31:0]        last_time;
  logic               active;
  mode_t              smode;
  logic               sabs;
  logic signed [31:0] sval [4];

  // working registers
  ang_t                      h_idx;
  logic signed [ACC_W-1:0]   acc;
  logic signed [VEL_W-1:0]   vt;
  logic signed [VEL_W-1:0]   vn;
  logic signed [VEL_W-1:0]   rndr;
  logic signed [31:0]        wheel [4];
  logic                      stop;
  logic                      out_valid;

  logic                      accept;
  logic [31:0]               elapsed;
  logic                      timed_out;
  mac_t                      mac;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [RND_W-1:0]   rnd;
  logic signed [31:0]        wsat;
  logic signed [TRIG_W-1:0]  h_sin, h_cos, w_sin, w_cos;
  ang_t                      w_idx;

  assign req.ready = cmd.take;
  assign accept    = req.valid && cmd.take;
  assign elapsed   = req.now_ms - last_time;
  assign timed_out = elapsed > {16'd0, timeout_ms};

  assign sts.upd       = req.valid && (req.req_type == REQ_UPDATE);
  assign sts.timed_out = timed_out;
  assign sts.active    = active;
  assign sts.mode      = smode;
  assign sts.absolute  = sabs;
  assign sts.out_busy  = out_valid && !rsp.ready;

  assign h_sin = sin_lookup(h_idx);
  assign h_cos = cos_lookup(h_idx);
  assign w_idx = angle_index(wang[cmd.wheel]);
  assign w_sin = sin_lookup(w_idx);
  assign w_cos = cos_lookup(w_idx);

  always_comb begin
    mac   = MAC_HOLD;
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_G0: begin mac = MAC_LOAD; mul_a = MUL_A_W'(sval[0]); mul_b = MUL_B_W'(h_cos); end
      OP_G1: begin mac = MAC_ADD;  mul_a = MUL_A_W'(sval[1]); mul_b = MUL_B_W'(h_sin); end
      OP_G2: begin mac = MAC_LOAD; mul_a = MUL_A_W'(sval[1]); mul_b = MUL_B_W'(h_cos); end
      OP_G3: begin mac = MAC_SUB;  mul_a = MUL_A_W'(sval[0]); mul_b = MUL_B_W'(h_sin); end
      OP_W0: begin
        mac   = MAC_LOAD;
        mul_a = MUL_A_W'(sval[2]);
        mul_b = $signed({{(MUL_B_W-16){1'b0}}, body_radius});
      end
      OP_W1: begin mac = MAC_SUB;  mul_a = vt; mul_b = MUL_B_W'(w_sin); end
      OP_W2: begin mac = MAC_ADD;  mul_a = vn; mul_b = MUL_B_W'(w_cos); end
      OP_W4: begin
        mac   = MAC_LOAD;
        mul_a = rndr;
        mul_b = $signed({{(MUL_B_W-24){1'b0}}, inv_r});
      end
      default: mac = MAC_HOLD;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod);
  assign rnd      = round16(acc);

  always_comb begin
    if (rnd > S32_MAX) begin
      wsat = 32'sh7FFF_FFFF;
    end else if (rnd < S32_MIN) begin
      wsat = 32'sh8000_0000;
    end else begin
      wsat = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_id    <= 8'd0;
      timeout_ms  <= 16'd100;
      body_radius <= 16'd5898;
      inv_r       <= 24'd2383127;
      wang[0]     <= 16'd5461;
      wang[1]     <= 16'd27307;
      wang[2]     <= 16'd40960;
      wang[3]     <= 16'd57344;
      last_time   <= '0;
      active      <= 1'b0;
      smode       <= MODE_UNSET;
      sabs        <= 1'b0;
      for (int k = 0; k < 4; k++) sval[k] <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROBOT_ID: robot_id    <= cfg_wdata[7:0];
          CFG_TIMEOUT:  timeout_ms  <= cfg_wdata[15:0];
          CFG_BODY_R:   body_radius <= cfg_wdata[15:0];
          CFG_INV_R:    inv_r       <= cfg_wdata;
          CFG_ANG0:     wang[0]     <= cfg_wdata[15:0];
          CFG_ANG1:     wang[1]     <= cfg_wdata[15:0];
          CFG_ANG2:     wang[2]     <= cfg_wdata[15:0];
          CFG_ANG3:     wang[3]     <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (req.req_type == REQ_COMMAND) begin
          if (req.target_id == robot_id) begin
            smode     <= mode_t'(req.mode);
            sabs      <= req.absolute_angle;
            sval[0]   <= req.value_a;
            sval[1]   <= req.value_b;
            sval[2]   <= req.value_c;
            sval[3]   <= req.value_d;
            last_time <= req.now_ms;
            active    <= 1'b1;
          end
        end else if (timed_out) begin
          active <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (accept && req.req_type == REQ_UPDATE) begin
      // wheels mode and timeout results are ready straight away
      stop  <= timed_out;
      h_idx <= angle_index(req.heading);
      vt    <= VEL_W'(sval[0]);
      vn    <= VEL_W'(sval[1]);
      for (int k = 0; k < 4; k++) wheel[k] <= timed_out ? '0 : sval[k];
    end
    case (mac)
      MAC_LOAD: acc <= prod_ext;
      MAC_ADD:  acc <= acc + prod_ext;
      MAC_SUB:  acc <= acc - prod_ext;
      default:  acc <= acc;
    endcase
    case (cmd.op)
      OP_G2:   vt   <= VEL_W'(rnd);
      OP_G4:   vn   <= VEL_W'(rnd);
      OP_W3:   rndr <= VEL_W'(rnd);
      OP_W5:   wheel[cmd.wheel] <= wsat;
      default: ;
    endcase
    if (cmd.out_load) begin
      rsp.wheel0_target <= wheel[0];
      rsp.wheel1_target <= wheel[1];
      rsp.wheel2_target <= wheel[2];
      rsp.wheel3_target <= wheel[3];
      rsp.timeout_stop  <= stop;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

>>> hdl/omni_drive_wheel_command.sv
`default_nettype none
// Four-wheel omni drive command block. Command items for this robot id are
// stored with their time and give no result; update items check the command
// timeout and then turn the stored command into four saturated wheel targets.
// A timeout gives a stop item only while a command is active; global mode
// with absolute angle and an unset mode give no result. All products go
// through one shared multiply-accumulate unit, six steps per wheel plus five
// for the heading rotation. The result sits in an output register, so the
// next item is taken while it waits.
module omni_drive_wheel_command (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [odwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odwc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  odwc_req_if.sink                        req,
  odwc_rsp_if.source                      rsp
);
  import odwc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  odwc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  odwc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.timeout_stop |->
      rsp.wheel0_target == 32'sd0 && rsp.wheel1_target == 32'sd0 &&
      rsp.wheel2_target == 32'sd0 && rsp.wheel3_target == 32'sd0)
    else $error("timeout stop item with non-zero wheels");

  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && sts.upd && sts.timed_out |=> !sts.active)
    else $error("active still set after timeout");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result register overwritten while held");

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import odwc_pkg::*;

  typedef struct {
    logic              req_type;
    logic [7:0]        target_id;
    mode_t             mode;
    logic              absolute_angle;
    logic signed [31:0] val [4];
    logic [15:0]       heading;
    logic [31:0]       now_ms;
  } drive_req_t;

  typedef struct {
    logic signed [31:0] wheel [4];
    logic               stop;
  } wheel_cmd_t;

  // Tracks what the block should hold and the wheel targets it owes.
  class wheel_scoreboard;
    logic [7:0]  robot_id = 8'd0;
    logic [15:0] timeout_ms = 16'd100;
    logic [15:0] body_r = 16'd5898;
    logic [23:0] inv_r = 24'd2383127;
    logic [15:0] mount [4] = '{16'd5461, 16'd27307, 16'd40960, 16'd57344};
    logic [31:0] last_cmd = '0;
    bit          active;
    mode_t       st_mode = MODE_UNSET;
    logic        st_abs;
    logic signed [31:0] st_val [4] = '{0, 0, 0, 0};
    wheel_cmd_t  owed [$];
    int          errors;

    function void set_reg(cfg_idx_t idx, logic [23:0] d);
      case (idx)
        CFG_ROBOT_ID: robot_id = d[7:0];
        CFG_TIMEOUT: timeout_ms = d[15:0];
        CFG_BODY_R: body_r = d[15:0];
        CFG_INV_R: inv_r = d;
        default: mount[idx - CFG_ANG0] = d[15:0];
      endcase
    endfunction

    function void owe(wheel_cmd_t o);
      owed = {owed, o};
    endfunction

    function logic [9:0] step_of(logic [15:0] a);
      logic [16:0] s;
      s = {1'b0, a} + 17'd32;
      return s[15:6];
    endfunction

    function longint quarter_sine(int k);
      longint unsigned x, x2, term;
      x = (longint'(k) * 64'd1686629713) >> 8;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      for (int n = 5; n >= 1; n--)
        term = (64'd1 << 30) - (((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1)));
      return longint'((((term * x) >> 30) + 64'd8192) >> 14);
    endfunction

    function longint sine(logic [9:0] i);
      logic [1:0] q;
      int r;
      longint v;
      q = i[9:8];
      r = i[7:0];
      v = quarter_sine(q[0] ? 256 - r : r);
      return q[1] ? -v : v;
    endfunction

    function longint rnd16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function wheel_cmd_t omni(longint vt, longint vn, longint w);
      wheel_cmd_t o;
      longint sum, r;
      logic [9:0] a;
      for (int i = 0; i < 4; i++) begin
        a = step_of(mount[i]);
        sum = longint'(body_r) * w - vt * sine(a) + vn * sine(a + 10'd256);
        r = rnd16(rnd16(sum) * longint'(inv_r));
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        o.wheel[i] = r[31:0];
      end
      o.stop = 1'b0;
      return o;
    endfunction

    function void note(drive_req_t it);
      wheel_cmd_t o;
      logic [31:0] gap;
      longint x, y, s, c;
      logic [9:0] h;
      if (it.req_type == REQ_COMMAND) begin
        if (it.target_id != robot_id) return;
        st_mode = it.mode;
        st_abs = it.absolute_angle;
        st_val = it.val;
        last_cmd = it.now_ms;
        active = 1;
        return;
      end
      gap = it.now_ms - last_cmd;
      if (gap > timeout_ms) begin
        if (active) begin
          active = 0;
          o.wheel = '{0, 0, 0, 0};
          o.stop = 1'b1;
          owe(o);
        end
        return;
      end
      case (st_mode)
        MODE_WHEELS: begin
          o.wheel = st_val;
          o.stop = 1'b0;
          owe(o);
        end
        MODE_GLOBAL: if (!st_abs) begin
          h = step_of(it.heading);
          x = st_val[0];
          y = st_val[1];
          s = sine(h);
          c = sine(h + 10'd256);
          owe(omni(rnd16(x * c + y * s), rnd16(y * c - x * s), st_val[2]));
        end
        MODE_ROBOT: owe(omni(st_val[0], st_val[1], st_val[2]));
        default: ;
      endcase
    endfunction

    function void check(wheel_cmd_t got);
      wheel_cmd_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected wheel item, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = owed.pop_front();
      for (int i = 0; i < 4; i++)
        if (got.wheel[i] !== e.wheel[i]) begin
          $display("%0t: wheel%0d_target expected %0d actual %0d", $time, i,
                   e.wheel[i], got.wheel[i]);
          errors++;
        end
      if (got.stop !== e.stop) begin
        $display("%0t: timeout_stop expected %0b actual %0b", $time, e.stop, got.stop);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 5000;

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  odwc_req_if req ();
  odwc_rsp_if rsp ();

  omni_drive_wheel_command u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .req(req.sink), .rsp(rsp.source)
  );

  always #4 clk = ~clk;

  wheel_scoreboard sb = new();
  logic [31:0] now_t;
  bit hold_req;
  bit stim_done;

  // write enable is lowered by the caller once the burst of writes is over
  task automatic write_reg(cfg_idx_t idx, logic [23:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic send(drive_req_t it);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= it.req_type;
    req.target_id <= it.target_id;
    req.mode <= it.mode;
    req.absolute_angle <= it.absolute_angle;
    req.value_a <= it.val[0];
    req.value_b <= it.val[1];
    req.value_c <= it.val[2];
    req.value_d <= it.val[3];
    req.heading <= it.heading;
    req.now_ms <= it.now_ms;
    do @(posedge clk); while (!req.ready);
    sb.note(it);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
    endcase
  endfunction

  function automatic drive_req_t make_item(bit is_upd, bit own_id);
    drive_req_t it;
    it.req_type = is_upd ? REQ_UPDATE : REQ_COMMAND;
    it.target_id = own_id ? sb.robot_id : 8'($urandom());
    it.mode = mode_t'($urandom_range(0, 3));
    it.absolute_angle = ($urandom_range(0, 3) == 0);
    foreach (it.val[i]) it.val[i] = rand_val();
    it.heading = $urandom();
    case ($urandom_range(0, 19))
      0: now_t = now_t + 32'($urandom_range(1, 200000)) + sb.timeout_ms;
      1: now_t = now_t - 32'($urandom_range(1, 50));
      2: now_t = $urandom();
      default: now_t = now_t + 32'($urandom_range(0, sb.timeout_ms / 4));
    endcase
    it.now_ms = now_t;
    return it;
  endfunction

  task automatic quiesce();
    req.valid <= 1'b0;
    @(posedge clk);
    wait (sb.owed.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic config_all(logic [23:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    drive_req_t it;
    mode_t m;
    // every mode, stored then applied, with field extremes
    for (int i = 0; i < 4; i++) begin
      m = mode_t'(i);
      it = make_item(0, 1);
      it.mode = m;
      it.absolute_angle = 1'b0;
      if (i == 2)
        it.val = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0};
      else
        it.val = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      it.now_ms = now_t;
      send(it);
      it.req_type = REQ_UPDATE;
      it.heading = 16'hffff;
      send(it);
    end
    // global mode with absolute angle, then absolute flag in robot mode
    it.req_type = REQ_COMMAND;
    it.mode = MODE_GLOBAL;
    it.absolute_angle = 1'b1;
    send(it);
    it.req_type = REQ_UPDATE;
    send(it);
    it.req_type = REQ_COMMAND;
    it.mode = MODE_ROBOT;
    it.val = '{32'h10000, -32'sh20000, 32'h8000, 0};
    send(it);
    it.req_type = REQ_UPDATE;
    send(it);
    // wrong robot id is dropped
    it.req_type = REQ_COMMAND;
    it.target_id = sb.robot_id + 8'd1;
    it.mode = MODE_WHEELS;
    send(it);
    it.req_type = REQ_UPDATE;
    send(it);
    // timeout while active, then again while inactive
    now_t = now_t + sb.timeout_ms + 1;
    it.now_ms = now_t;
    send(it);
    send(it);
    // clock running backwards reads as long silence
    it.req_type = REQ_COMMAND;
    it.target_id = sb.robot_id;
    it.now_ms = now_t;
    send(it);
    it.req_type = REQ_UPDATE;
    it.now_ms = now_t - 1;
    send(it);
    // update exactly at the limit, inactive, stored mode still applied
    it.now_ms = now_t + sb.timeout_ms;
    send(it);
    quiesce();
  endtask

  task automatic random_phase(int n, bit pressure);
    drive_req_t it;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 2) hold_req = 1;
      it = make_item($urandom_range(0, 2) != 0, $urandom_range(0, 7) != 0);
      send(it);
    end
    quiesce();
  endtask

  initial begin
    logic [23:0] v [8];
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    req.valid <= 1'b0;
    req.req_type <= REQ_COMMAND;
    req.target_id <= '0;
    req.mode <= MODE_WHEELS;
    req.absolute_angle <= 1'b0;
    req.value_a <= '0;
    req.value_b <= '0;
    req.value_c <= '0;
    req.value_d <= '0;
    req.heading <= '0;
    req.now_ms <= '0;
    now_t = 32'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    random_phase(100, 1);

    v = '{24'd255, 24'd65535, 24'd65535, 24'hffffff, 24'd65535, 24'd0, 24'd32768, 24'd16384};
    config_all(v);
    random_phase(80, 0);

    v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd65535, 24'd1, 24'd49152};
    config_all(v);
    random_phase(60, 0);

    for (int i = 0; i < 8; i++) v[i] = $urandom();
    v[1] = $urandom_range(5, 2000);
    config_all(v);
    directed();
    random_phase(150, 1);

    stim_done = 1;
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls per item, plus one long hold-off when asked
  initial begin
    int stall;
    wheel_cmd_t got;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.wheel = '{rsp.wheel0_target, rsp.wheel1_target, rsp.wheel2_target,
                      rsp.wheel3_target};
        got.stop = rsp.timeout_stop;
        sb.check(got);
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      end
      if (hold_req) begin
        hold_req = 0;
        stall = 400;
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else
        rsp.ready <= 1'b1;
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT && !stim_done) begin
        $display("%0t: watchdog expired, %0d items outstanding", $time, sb.owed.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire

>>> filelist.f
hdl/odwc_pkg.sv
hdl/odwc_if.sv
hdl/odwc_ctrl.sv
hdl/odwc_datapath.sv
hdl/omni_drive_wheel_command.sv
verif/tb.sv
